@@ hdl/s2k_pkg.sv @@
// package: types, codes, keymap table and translation helpers
package s2k_pkg;

  localparam int unsigned FifoDepthDefault = 16;
  localparam logic [7:0]  KeymapRows = 8'h59;

  typedef enum logic [2:0] {
    KIND_SCAN     = 3'd0,
    KIND_READ     = 3'd1,
    KIND_PEEK     = 3'd2,
    KIND_READ_EXT = 3'd3,
    KIND_PEEK_EXT = 3'd4,
    KIND_STORE    = 3'd5,
    KIND_SHIFT    = 3'd6,
    KIND_EXTFLAGS = 3'd7
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  scan_byte;
    logic [15:0] store_word;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] result_word;
    logic        empty_res;
    logic        full_res;
    logic        reset_request;
  } out_beat_t;

  // scancode decoder outcome, handed to the fifo
  typedef struct packed {
    logic        push;
    logic [15:0] word;
    logic        reset_req;
  } scan_res_t;

  function automatic logic [63:0] keymap_row(input logic [6:0] sc);
    logic [63:0] r;
    r = '0;
    unique case (sc)
      7'h01: r = {16'h011b,16'h011b,16'h011b,16'h01f0};
      7'h02: r = {16'h0231,16'h0221,16'h0000,16'h7800};
      7'h03: r = {16'h0332,16'h0340,16'h0300,16'h7900};
      7'h04: r = {16'h0433,16'h0423,16'h0000,16'h7a00};
      7'h05: r = {16'h0534,16'h0524,16'h0000,16'h7b00};
      7'h06: r = {16'h0635,16'h0625,16'h0000,16'h7c00};
      7'h07: r = {16'h0736,16'h075e,16'h071e,16'h7d00};
      7'h08: r = {16'h0837,16'h0826,16'h0000,16'h7e00};
      7'h09: r = {16'h0938,16'h092a,16'h0000,16'h7f00};
      7'h0a: r = {16'h0a39,16'h0a28,16'h0000,16'h8000};
      7'h0b: r = {16'h0b30,16'h0b29,16'h0000,16'h8100};
      7'h0c: r = {16'h0c2d,16'h0c5f,16'h0c1f,16'h8200};
      7'h0d: r = {16'h0d3d,16'h0d2b,16'h0000,16'h8300};
      7'h0e: r = {16'h0e08,16'h0e08,16'h0e7f,16'h0ef0};
      7'h0f: r = {16'h0f09,16'h0f00,16'h9400,16'ha5f0};
      7'h10: r = {16'h1071,16'h1051,16'h1011,16'h1000};
      7'h11: r = {16'h1177,16'h1157,16'h1117,16'h1100};
      7'h12: r = {16'h1265,16'h1245,16'h1205,16'h1200};
      7'h13: r = {16'h1372,16'h1352,16'h1312,16'h1300};
      7'h14: r = {16'h1474,16'h1454,16'h1414,16'h1400};
      7'h15: r = {16'h1579,16'h1559,16'h1519,16'h1500};
      7'h16: r = {16'h1675,16'h1655,16'h1615,16'h1600};
      7'h17: r = {16'h1769,16'h1749,16'h1709,16'h1700};
      7'h18: r = {16'h186f,16'h184f,16'h180f,16'h1800};
      7'h19: r = {16'h1970,16'h1950,16'h1910,16'h1900};
      7'h1a: r = {16'h1a5b,16'h1a7b,16'h1a1b,16'h1af0};
      7'h1b: r = {16'h1b5d,16'h1b7d,16'h1b1d,16'h1bf0};
      7'h1c: r = {16'h1c0d,16'h1c0d,16'h1c0a,16'h1cf0};
      7'h1e: r = {16'h1e61,16'h1e41,16'h1e01,16'h1e00};
      7'h1f: r = {16'h1f73,16'h1f53,16'h1f13,16'h1f00};
      7'h20: r = {16'h2064,16'h2044,16'h2004,16'h2000};
      7'h21: r = {16'h2166,16'h2146,16'h2106,16'h2100};
      7'h22: r = {16'h2267,16'h2247,16'h2207,16'h2200};
      7'h23: r = {16'h2368,16'h2348,16'h2308,16'h2300};
      7'h24: r = {16'h246a,16'h244a,16'h240a,16'h2400};
      7'h25: r = {16'h256b,16'h254b,16'h250b,16'h2500};
      7'h26: r = {16'h266c,16'h264c,16'h260c,16'h2600};
      7'h27: r = {16'h273b,16'h273a,16'h0000,16'h27f0};
      7'h28: r = {16'h2827,16'h2822,16'h0000,16'h28f0};
      7'h29: r = {16'h2960,16'h297e,16'h0000,16'h29f0};
      7'h2b: r = {16'h2b5c,16'h2b7c,16'h2b1c,16'h2bf0};
      7'h2c: r = {16'h2c7a,16'h2c5a,16'h2c1a,16'h2c00};
      7'h2d: r = {16'h2d78,16'h2d58,16'h2d18,16'h2d00};
      7'h2e: r = {16'h2e63,16'h2e43,16'h2e03,16'h2e00};
      7'h2f: r = {16'h2f76,16'h2f56,16'h2f16,16'h2f00};
      7'h30: r = {16'h3062,16'h3042,16'h3002,16'h3000};
      7'h31: r = {16'h316e,16'h314e,16'h310e,16'h3100};
      7'h32: r = {16'h326d,16'h324d,16'h320d,16'h3200};
      7'h33: r = {16'h332c,16'h333c,16'h0000,16'h33f0};
      7'h34: r = {16'h342e,16'h343e,16'h0000,16'h34f0};
      7'h35: r = {16'h352f,16'h353f,16'h0000,16'h35f0};
      7'h37: r = {16'h372a,16'h372a,16'h9600,16'h37f0};
      7'h39: r = {16'h3920,16'h3920,16'h3920,16'h3920};
      7'h3b: r = {16'h3b00,16'h5400,16'h5e00,16'h6800};
      7'h3c: r = {16'h3c00,16'h5500,16'h5f00,16'h6900};
      7'h3d: r = {16'h3d00,16'h5600,16'h6000,16'h6a00};
      7'h3e: r = {16'h3e00,16'h5700,16'h6100,16'h6b00};
      7'h3f: r = {16'h3f00,16'h5800,16'h6200,16'h6c00};
      7'h40: r = {16'h4000,16'h5900,16'h6300,16'h6d00};
      7'h41: r = {16'h4100,16'h5a00,16'h6400,16'h6e00};
      7'h42: r = {16'h4200,16'h5b00,16'h6500,16'h6f00};
      7'h43: r = {16'h4300,16'h5c00,16'h6600,16'h7000};
      7'h44: r = {16'h4400,16'h5d00,16'h6700,16'h7100};
      7'h47: r = {16'h4700,16'h4737,16'h7700,16'h0000};
      7'h48: r = {16'h4800,16'h4838,16'h8d00,16'h0000};
      7'h49: r = {16'h4900,16'h4939,16'h8400,16'h0000};
      7'h4a: r = {16'h4a2d,16'h4a2d,16'h8e00,16'h4af0};
      7'h4b: r = {16'h4b00,16'h4b34,16'h7300,16'h0000};
      7'h4c: r = {16'h4c00,16'h4c35,16'h8f00,16'h0000};
      7'h4d: r = {16'h4d00,16'h4d36,16'h7400,16'h0000};
      7'h4e: r = {16'h4e2b,16'h4e2b,16'h9000,16'h4ef0};
      7'h4f: r = {16'h4f00,16'h4f31,16'h7500,16'h0000};
      7'h50: r = {16'h5000,16'h5032,16'h9100,16'h0000};
      7'h51: r = {16'h5100,16'h5133,16'h7600,16'h0000};
      7'h52: r = {16'h5200,16'h5230,16'h9200,16'h0000};
      7'h53: r = {16'h5300,16'h532e,16'h9300,16'h0000};
      7'h56: r = {16'h565c,16'h567c,16'h0000,16'h0000};
      7'h57: r = {16'h8500,16'h8700,16'h8900,16'h8b00};
      7'h58: r = {16'h8600,16'h8800,16'h8a00,16'h8c00};
      default: r = '0;
    endcase
    return r;
  endfunction

  // fixups applied on the way out of the fifo
  function automatic logic [15:0] read_fix(input logic [15:0] kc_in, input logic std_rd);
    logic [15:0] kc;
    logic [7:0]  lo;
    kc = kc_in;
    lo = kc_in[7:0];
    if (std_rd) begin
      if (lo == 8'he0 && kc[15:8] != 8'h00) kc = {kc[15:8], 8'h00};
      else if (kc == 16'he00d || kc == 16'he00a) kc = {8'h1c, lo};
      else if (kc == 16'he02f) kc = 16'h352f;
    end
    if (lo == 8'hf0 && kc[15:8] != 8'h00) kc = {kc[15:8], 8'h00};
    return kc;
  endfunction

endpackage

@@ hdl/s2k_if.sv @@
// handshake channel interfaces for input and result beats
interface s2k_in_if;
  logic              valid;
  logic              ready;
  s2k_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface s2k_out_if;
  logic               valid;
  logic               ready;
  s2k_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/scancode_to_keycode_with_key_fifo.sv @@
// top level: set-1 scancode translator with keycode fifo
//
//  channel  dir  payload                                         beat taken when
//  in_ch    in   kind, scan_byte, store_word                     valid & ready
//  out_ch   out  result_word, empty_res, full_res, reset_request valid & ready
//
// one beat in, one result beat out, one beat per cycle sustained while the receiver keeps taking results
// each item is handled combinationally: decode and fifo update, result registered
// a single output register; in ready whenever it is empty or taken this cycle
// async reset clears flags, prefixes, fifo head and count; fifo data stays unset
module scancode_to_keycode_with_key_fifo #(
  parameter int unsigned FifoDepth = s2k_pkg::FifoDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  s2k_in_if.sink          in_ch,
  s2k_out_if.source       out_ch
);
  logic                 take, out_vld_q, out_vld_d;
  s2k_pkg::out_beat_t   res_d, res_q;
  s2k_pkg::scan_res_t   sres;
  logic [15:0]          sflags, head_word;
  logic [4:0]           pflags;
  logic                 f_empty, f_full, push, pop;
  logic [15:0]          push_word;
  s2k_pkg::kind_e       kind;

  // accept while output slot is free or draining
  assign in_ch.ready = !out_vld_q || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign kind = s2k_pkg::kind_e'(in_ch.data.kind);

  s2k_decode u_decode (
    .clk_i,
    .rst_ni,
    .en_i           (take && kind == s2k_pkg::KIND_SCAN),
    .byte_i         (in_ch.data.scan_byte),
    .shift_flags_o  (sflags),
    .prefix_flags_o (pflags),
    .res_o          (sres)
  );

  s2k_fifo #(.FifoDepth(FifoDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .empty_o     (f_empty),
    .full_o      (f_full),
    .head_word_o (head_word)
  );

  always_comb begin
    res_d = '0;
    push = 1'b0;
    pop = 1'b0;
    push_word = in_ch.data.store_word;
    unique case (kind)
      s2k_pkg::KIND_SCAN: begin
        push = take && sres.push;
        push_word = sres.word;
        res_d.full_res = sres.push && f_full;
        res_d.reset_request = sres.reset_req;
      end
      s2k_pkg::KIND_READ, s2k_pkg::KIND_PEEK,
      s2k_pkg::KIND_READ_EXT, s2k_pkg::KIND_PEEK_EXT: begin
        if (f_empty) res_d.empty_res = 1'b1;
        else res_d.result_word = s2k_pkg::read_fix(head_word,
          kind == s2k_pkg::KIND_READ || kind == s2k_pkg::KIND_PEEK);
        pop = take && (kind == s2k_pkg::KIND_READ || kind == s2k_pkg::KIND_READ_EXT);
      end
      s2k_pkg::KIND_STORE: begin
        push = take;
        res_d.full_res = f_full;
      end
      s2k_pkg::KIND_SHIFT: res_d.result_word = {8'h00, sflags[7:0]};
      s2k_pkg::KIND_EXTFLAGS:
        res_d.result_word = {sflags[15:12], pflags[3:2], sflags[9:0]};
      default: res_d = '0;
    endcase
  end

  assign out_vld_d = take || (out_vld_q && !out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = res_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(res_q))
    else $error("result lost under stall");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({res_d.empty_res, res_d.full_res, res_d.reset_request}) <= 1)
    else $error("conflicting status bits");
  a_take_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_vld_q) else $error("accepted beat gave no result");
endmodule

@@ hdl/s2k_decode.sv @@
// scancode decoder: prefix marks, modifier and lock flags, keymap lookup
module s2k_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  output logic [15:0]       shift_flags_o,
  output logic [4:0]        prefix_flags_o,
  output s2k_pkg::scan_res_t res_o
);
  logic [15:0] sf_q, sf_d;
  logic [4:0]  pf_q, pf_d;
  logic        rel, e0, e1, mod, lookup, numpad, caps_hit, sh;
  logic [6:0]  sc;
  logic [15:0] set0, tog, kc, r0, r1, r2, r3;
  logic [4:0]  set1;
  logic [63:0] row;

  always_comb begin
    rel = byte_i[7];
    sc = byte_i[6:0];
    e0 = pf_q[1];
    e1 = pf_q[0];
    sf_d = sf_q;
    pf_d = pf_q;
    set0 = '0; set1 = '0; tog = '0;
    mod = 1'b0;
    lookup = 1'b0;
    res_o = '0;
    kc = '0;
    row = s2k_pkg::keymap_row(sc);
    if (e0 && sc == 7'h1c) row = {16'he00d, 16'he00d, 16'he00a, 16'ha600};
    if (e0 && sc == 7'h35) row = {16'he02f, 16'he02f, 16'h9500, 16'ha400};
    {r0, r1, r2, r3} = row;
    numpad = sc >= 7'h47 && sc <= 7'h53;
    caps_hit = r0[7:0] >= 8'h61 && r0[7:0] <= 8'h7a;
    sh = (sf_q[1:0] != 2'b00) ^ ((sf_q[5] && numpad) || (sf_q[6] && caps_hit));
    if (sf_q[3]) kc = r3;
    else if (sf_q[2]) kc = r2;
    else kc = sh ? r1 : r0;
    if (e0 && numpad) begin
      if (sf_q[3]) kc = {{1'b0, sc} + 8'h50, 8'h00};
      else kc = {kc[15:8], 8'he0};
    end
    if (en_i) begin
      if (byte_i == 8'he0 || byte_i == 8'he1) begin
        pf_d = pf_q | (byte_i == 8'he0 ? 5'b00010 : 5'b00001);
      end else if (!(e1 && sc == 7'h1d)) begin
        if (e0 || e1) pf_d = pf_q & 5'b11100;
        unique case (sc)
          7'h3a: begin mod = 1'b1; set0 = 16'h4000; tog = 16'h0040; end
          7'h2a: begin mod = !e0; set0 = 16'h0002; end
          7'h36: begin mod = !e0; set0 = 16'h0001; end
          7'h1d: begin
            mod = 1'b1;
            if (e0) begin set0 = 16'h0004; set1 = 5'b00100; end
            else set0 = 16'h0104;
          end
          7'h38: begin
            mod = 1'b1;
            if (e0) begin set0 = 16'h0008; set1 = 5'b01000; end
            else set0 = 16'h0208;
          end
          7'h45: begin mod = !e1; set0 = 16'h2000; tog = 16'h0020; end
          7'h46: begin mod = !e0; set0 = 16'h1000; tog = 16'h0010; end
          7'h37: lookup = !e0;
          7'h54: lookup = 1'b0;
          7'h53: begin
            if (sf_q[3:2] == 2'b11 && !rel) res_o.reset_req = 1'b1;
            else lookup = 1'b1;
          end
          default: lookup = 1'b1;
        endcase
        if (mod) begin
          if (rel) begin
            sf_d = sf_q & ~set0;
            pf_d = pf_d & ~set1;
          end else begin
            sf_d = (sf_q ^ tog) | set0;
            pf_d = pf_d | set1;
          end
        end
        if (lookup && !rel && sc != 7'h00 && sc < s2k_pkg::KeymapRows[6:0] &&
            kc != 16'h0) begin
          res_o.push = 1'b1;
          res_o.word = kc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= '0;
      pf_q <= '0;
    end else begin
      sf_q <= sf_d;
      pf_q <= pf_d;
    end
  end

  assign shift_flags_o  = sf_q;
  assign prefix_flags_o = pf_q;

  a_pf_bit4: assert property (@(posedge clk_i) disable iff (!rst_ni) !pf_q[4])
    else $error("unused prefix bit set");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.push && res_o.reset_req)) else $error("push with reset request");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(sf_q) && $stable(pf_q)) else $error("flags moved while idle");
endmodule

@@ hdl/s2k_fifo.sv @@
// keycode fifo: circular buffer with head and count
module s2k_fifo #(
  parameter int unsigned FifoDepth = s2k_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [15:0] push_word_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        full_o,
  output logic [15:0] head_word_o
);
  localparam int unsigned AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CW = $clog2(FifoDepth + 1);

  logic [15:0]   mem_q [FifoDepth];
  logic [15:0]   head_word_q;
  logic [AW-1:0] head_q, head_d, wr_idx;
  logic [CW-1:0] count_q, count_d;
  logic [AW:0]   wsum;
  logic          do_push, do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CW'(FifoDepth);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_word_o = head_word_q;

  always_comb begin
    wsum = {1'b0, head_q} + (AW + 1)'(count_q);
    wr_idx = (wsum >= (AW + 1)'(FifoDepth)) ? AW'(wsum - (AW + 1)'(FifoDepth)) : wsum[AW-1:0];
    head_d = head_q;
    if (do_pop) head_d = (head_q == AW'(FifoDepth - 1)) ? '0 : head_q + AW'(1);
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // head word kept in a register: loaded on push into empty, refetched on pop
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_idx] <= push_word_i;
    if (do_push && empty_o) head_word_q <= push_word_i;
    else if (do_pop) head_word_q <= mem_q[head_d];
  end

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && pop_i))
    else $error("push and pop together");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FifoDepth)) else $error("count overflow");
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |=> $stable(count_q)) else $error("push into full fifo");
endmodule

@@ dv/tb_top.sv @@
// testbench: scancode translator with key fifo, predicted and checked beat by beat
`timescale 1ns / 100ps

module tb_top;

  logic clk_i;
  logic rst_ni;

  s2k_in_if  in_ch ();
  s2k_out_if out_ch ();

  scancode_to_keycode_with_key_fifo i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  localparam int unsigned Depth = s2k_pkg::FifoDepthDefault;
  localparam int unsigned CycleLimit = 400000;

  // predictor state: flags, prefix marks, own copy of the key queue
  logic [15:0] kbd_flags;
  logic [4:0]  kbd_prefix;
  logic [15:0] key_q[$];

  s2k_pkg::out_beat_t expected_beats[$];
  int unsigned err_cnt;
  int unsigned cyc_cnt;

  // idling knobs, in percent
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_off;

  // table rows, same content as the keyboard layout: normal, shift, ctrl, alt
  function automatic logic [63:0] layout_row(input logic [6:0] sc);
    logic [15:0] t [0:88][0:3];
    t = '{default: '{default: 16'h0}};
    t[8'h01]='{16'h011b,16'h011b,16'h011b,16'h01f0};
    t[8'h02]='{16'h0231,16'h0221,16'h0000,16'h7800};
    t[8'h03]='{16'h0332,16'h0340,16'h0300,16'h7900};
    t[8'h04]='{16'h0433,16'h0423,16'h0000,16'h7a00};
    t[8'h05]='{16'h0534,16'h0524,16'h0000,16'h7b00};
    t[8'h06]='{16'h0635,16'h0625,16'h0000,16'h7c00};
    t[8'h07]='{16'h0736,16'h075e,16'h071e,16'h7d00};
    t[8'h08]='{16'h0837,16'h0826,16'h0000,16'h7e00};
    t[8'h09]='{16'h0938,16'h092a,16'h0000,16'h7f00};
    t[8'h0a]='{16'h0a39,16'h0a28,16'h0000,16'h8000};
    t[8'h0b]='{16'h0b30,16'h0b29,16'h0000,16'h8100};
    t[8'h0c]='{16'h0c2d,16'h0c5f,16'h0c1f,16'h8200};
    t[8'h0d]='{16'h0d3d,16'h0d2b,16'h0000,16'h8300};
    t[8'h0e]='{16'h0e08,16'h0e08,16'h0e7f,16'h0ef0};
    t[8'h0f]='{16'h0f09,16'h0f00,16'h9400,16'ha5f0};
    t[8'h10]='{16'h1071,16'h1051,16'h1011,16'h1000};
    t[8'h11]='{16'h1177,16'h1157,16'h1117,16'h1100};
    t[8'h12]='{16'h1265,16'h1245,16'h1205,16'h1200};
    t[8'h13]='{16'h1372,16'h1352,16'h1312,16'h1300};
    t[8'h14]='{16'h1474,16'h1454,16'h1414,16'h1400};
    t[8'h15]='{16'h1579,16'h1559,16'h1519,16'h1500};
    t[8'h16]='{16'h1675,16'h1655,16'h1615,16'h1600};
    t[8'h17]='{16'h1769,16'h1749,16'h1709,16'h1700};
    t[8'h18]='{16'h186f,16'h184f,16'h180f,16'h1800};
    t[8'h19]='{16'h1970,16'h1950,16'h1910,16'h1900};
    t[8'h1a]='{16'h1a5b,16'h1a7b,16'h1a1b,16'h1af0};
    t[8'h1b]='{16'h1b5d,16'h1b7d,16'h1b1d,16'h1bf0};
    t[8'h1c]='{16'h1c0d,16'h1c0d,16'h1c0a,16'h1cf0};
    t[8'h1e]='{16'h1e61,16'h1e41,16'h1e01,16'h1e00};
    t[8'h1f]='{16'h1f73,16'h1f53,16'h1f13,16'h1f00};
    t[8'h20]='{16'h2064,16'h2044,16'h2004,16'h2000};
    t[8'h21]='{16'h2166,16'h2146,16'h2106,16'h2100};
    t[8'h22]='{16'h2267,16'h2247,16'h2207,16'h2200};
    t[8'h23]='{16'h2368,16'h2348,16'h2308,16'h2300};
    t[8'h24]='{16'h246a,16'h244a,16'h240a,16'h2400};
    t[8'h25]='{16'h256b,16'h254b,16'h250b,16'h2500};
    t[8'h26]='{16'h266c,16'h264c,16'h260c,16'h2600};
    t[8'h27]='{16'h273b,16'h273a,16'h0000,16'h27f0};
    t[8'h28]='{16'h2827,16'h2822,16'h0000,16'h28f0};
    t[8'h29]='{16'h2960,16'h297e,16'h0000,16'h29f0};
    t[8'h2b]='{16'h2b5c,16'h2b7c,16'h2b1c,16'h2bf0};
    t[8'h2c]='{16'h2c7a,16'h2c5a,16'h2c1a,16'h2c00};
    t[8'h2d]='{16'h2d78,16'h2d58,16'h2d18,16'h2d00};
    t[8'h2e]='{16'h2e63,16'h2e43,16'h2e03,16'h2e00};
    t[8'h2f]='{16'h2f76,16'h2f56,16'h2f16,16'h2f00};
    t[8'h30]='{16'h3062,16'h3042,16'h3002,16'h3000};
    t[8'h31]='{16'h316e,16'h314e,16'h310e,16'h3100};
    t[8'h32]='{16'h326d,16'h324d,16'h320d,16'h3200};
    t[8'h33]='{16'h332c,16'h333c,16'h0000,16'h33f0};
    t[8'h34]='{16'h342e,16'h343e,16'h0000,16'h34f0};
    t[8'h35]='{16'h352f,16'h353f,16'h0000,16'h35f0};
    t[8'h37]='{16'h372a,16'h372a,16'h9600,16'h37f0};
    t[8'h39]='{16'h3920,16'h3920,16'h3920,16'h3920};
    t[8'h3b]='{16'h3b00,16'h5400,16'h5e00,16'h6800};
    t[8'h3c]='{16'h3c00,16'h5500,16'h5f00,16'h6900};
    t[8'h3d]='{16'h3d00,16'h5600,16'h6000,16'h6a00};
    t[8'h3e]='{16'h3e00,16'h5700,16'h6100,16'h6b00};
    t[8'h3f]='{16'h3f00,16'h5800,16'h6200,16'h6c00};
    t[8'h40]='{16'h4000,16'h5900,16'h6300,16'h6d00};
    t[8'h41]='{16'h4100,16'h5a00,16'h6400,16'h6e00};
    t[8'h42]='{16'h4200,16'h5b00,16'h6500,16'h6f00};
    t[8'h43]='{16'h4300,16'h5c00,16'h6600,16'h7000};
    t[8'h44]='{16'h4400,16'h5d00,16'h6700,16'h7100};
    t[8'h47]='{16'h4700,16'h4737,16'h7700,16'h0000};
    t[8'h48]='{16'h4800,16'h4838,16'h8d00,16'h0000};
    t[8'h49]='{16'h4900,16'h4939,16'h8400,16'h0000};
    t[8'h4a]='{16'h4a2d,16'h4a2d,16'h8e00,16'h4af0};
    t[8'h4b]='{16'h4b00,16'h4b34,16'h7300,16'h0000};
    t[8'h4c]='{16'h4c00,16'h4c35,16'h8f00,16'h0000};
    t[8'h4d]='{16'h4d00,16'h4d36,16'h7400,16'h0000};
    t[8'h4e]='{16'h4e2b,16'h4e2b,16'h9000,16'h4ef0};
    t[8'h4f]='{16'h4f00,16'h4f31,16'h7500,16'h0000};
    t[8'h50]='{16'h5000,16'h5032,16'h9100,16'h0000};
    t[8'h51]='{16'h5100,16'h5133,16'h7600,16'h0000};
    t[8'h52]='{16'h5200,16'h5230,16'h9200,16'h0000};
    t[8'h53]='{16'h5300,16'h532e,16'h9300,16'h0000};
    t[8'h56]='{16'h565c,16'h567c,16'h0000,16'h0000};
    t[8'h57]='{16'h8500,16'h8700,16'h8900,16'h8b00};
    t[8'h58]='{16'h8600,16'h8800,16'h8a00,16'h8c00};
    if (sc >= 7'h59) return '0;
    return {t[sc][0], t[sc][1], t[sc][2], t[sc][3]};
  endfunction

  // modifier press or release
  function automatic void apply_mod(input bit rel, input logic [15:0] set0,
                                    input logic [4:0] set1, input logic [15:0] tog);
    if (rel) begin
      kbd_flags  = kbd_flags & ~set0;
      kbd_prefix = kbd_prefix & ~set1;
    end else begin
      kbd_flags  = (kbd_flags ^ tog) | set0;
      kbd_prefix = kbd_prefix | set1;
    end
  endfunction

  // queue a keycode, report a drop when the queue is full
  function automatic bit queue_key(input logic [15:0] w);
    if (key_q.size() >= Depth) return 1'b1;
    key_q.push_back(w);
    return 1'b0;
  endfunction

  // scancode byte: returns the result beat for it
  function automatic s2k_pkg::out_beat_t translate_scan(input logic [7:0] b);
    s2k_pkg::out_beat_t r;
    logic [4:0]  p;
    logic [6:0]  sc;
    logic [63:0] row;
    logic [15:0] col [0:3];
    logic [15:0] f, kc;
    bit          rel, e0, e1, sh, done;
    r    = '0;
    p    = kbd_prefix;
    done = 1'b0;
    if (b == 8'he0 || b == 8'he1) begin
      kbd_prefix = p | ((b == 8'he0) ? 5'h02 : 5'h01);
      return r;
    end
    rel = b[7];
    sc  = b[6:0];
    e0  = p[1];
    e1  = p[0];
    if (e0 || e1) begin
      // pause sequence keeps the marks
      if (e1 && sc == 7'h1d) return r;
      kbd_prefix = p & 5'h1c;
    end
    case (sc)
      7'h3a: begin apply_mod(rel, 16'h4000, 5'h0, 16'h0040); done = 1; end
      7'h2a: begin if (!e0) apply_mod(rel, 16'h0002, 5'h0, 16'h0); done = 1; end
      7'h36: begin if (!e0) apply_mod(rel, 16'h0001, 5'h0, 16'h0); done = 1; end
      7'h1d: begin
        if (e0) apply_mod(rel, 16'h0004, 5'h04, 16'h0);
        else    apply_mod(rel, 16'h0104, 5'h00, 16'h0);
        done = 1;
      end
      7'h38: begin
        if (e0) apply_mod(rel, 16'h0008, 5'h08, 16'h0);
        else    apply_mod(rel, 16'h0208, 5'h00, 16'h0);
        done = 1;
      end
      7'h45: begin if (!e1) apply_mod(rel, 16'h2000, 5'h0, 16'h0020); done = 1; end
      7'h46: begin if (!e0) apply_mod(rel, 16'h1000, 5'h0, 16'h0010); done = 1; end
      7'h37: if (e0) done = 1;
      7'h54: done = 1;
      7'h53: if (kbd_flags[3:2] == 2'b11 && !rel) begin
        r.reset_request = 1'b1;
        done = 1;
      end
      default: ;
    endcase
    if (done || rel || sc == 0 || sc >= s2k_pkg::KeymapRows[6:0]) return r;
    row = layout_row(sc);
    if (e0 && sc == 7'h1c) row = {16'he00d, 16'he00d, 16'he00a, 16'ha600};
    if (e0 && sc == 7'h35) row = {16'he02f, 16'he02f, 16'h9500, 16'ha400};
    {col[0], col[1], col[2], col[3]} = row;
    f = kbd_flags;
    if (f[3])      kc = col[3];
    else if (f[2]) kc = col[2];
    else begin
      sh = (f[1:0] != 0);
      if ((f[5] && sc >= 7'h47 && sc <= 7'h53) ||
          (f[6] && col[0][7:0] >= 8'h61 && col[0][7:0] <= 8'h7a))
        sh = !sh;
      kc = sh ? col[1] : col[0];
    end
    if (e0 && sc >= 7'h47 && sc <= 7'h53) begin
      if (f[3]) kc = {8'(sc + 7'h50 + 8'h0), 8'h00};
      else      kc = {kc[15:8], 8'he0};
    end
    if (kc != 0) r.full_res = queue_key(kc);
    return r;
  endfunction

  // whole-beat predictor
  function automatic s2k_pkg::out_beat_t predict_beat(input s2k_pkg::in_beat_t it);
    s2k_pkg::out_beat_t r;
    logic [15:0]        kc;
    logic [7:0]         lo;
    s2k_pkg::kind_e     k;
    r = '0;
    k = s2k_pkg::kind_e'(it.kind);
    case (k)
      s2k_pkg::KIND_SCAN: r = translate_scan(it.scan_byte);
      s2k_pkg::KIND_READ, s2k_pkg::KIND_PEEK,
      s2k_pkg::KIND_READ_EXT, s2k_pkg::KIND_PEEK_EXT: begin
        if (key_q.size() == 0) r.empty_res = 1'b1;
        else begin
          kc = key_q[0];
          lo = kc[7:0];
          if (k == s2k_pkg::KIND_READ || k == s2k_pkg::KIND_PEEK) begin
            if (lo == 8'he0 && kc[15:8] != 0) kc = {kc[15:8], 8'h00};
            else if (kc == 16'he00d || kc == 16'he00a) kc = {8'h1c, lo};
            else if (kc == 16'he02f) kc = 16'h352f;
          end
          if (lo == 8'hf0 && kc[15:8] != 0) kc = {kc[15:8], 8'h00};
          r.result_word = kc;
          if (k == s2k_pkg::KIND_READ || k == s2k_pkg::KIND_READ_EXT)
            void'(key_q.pop_front());
        end
      end
      s2k_pkg::KIND_STORE: r.full_res = queue_key(it.store_word);
      s2k_pkg::KIND_SHIFT: r.result_word = {8'h00, kbd_flags[7:0]};
      default: r.result_word = {kbd_flags[15:12], kbd_prefix[3:2], kbd_flags[9:0]};
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CycleLimit) begin
      $display("%0t timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall, long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    s2k_pkg::out_beat_t exp_b;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, out_ch.data);
        err_cnt++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_ch.data.result_word !== exp_b.result_word ||
            out_ch.data.empty_res !== exp_b.empty_res ||
            out_ch.data.full_res !== exp_b.full_res ||
            out_ch.data.reset_request !== exp_b.reset_request) begin
          $display("%0t mismatch: expected word %h e/f/r %b%b%b, actual word %h e/f/r %b%b%b",
                   $time, exp_b.result_word, exp_b.empty_res, exp_b.full_res,
                   exp_b.reset_request, out_ch.data.result_word, out_ch.data.empty_res,
                   out_ch.data.full_res, out_ch.data.reset_request);
          err_cnt++;
        end
      end
    end
  end

  // drive one beat, predict at acceptance; an optional typed-in expectation is cross-checked
  task automatic send_beat(input s2k_pkg::in_beat_t it, input bit has_exp,
                           input s2k_pkg::out_beat_t typed);
    s2k_pkg::out_beat_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    p = predict_beat(it);
    if (has_exp && p !== typed) begin
      $display("%0t directed row: expected %h, predicted %h", $time, typed, p);
      err_cnt++;
    end
    expected_beats.push_back(p);
  endtask

  function automatic s2k_pkg::in_beat_t mk(input s2k_pkg::kind_e k, input logic [7:0] b,
                                           input logic [15:0] w);
    s2k_pkg::in_beat_t it;
    it.kind = k;
    it.scan_byte = b;
    it.store_word = w;
    return it;
  endfunction

  // random beat: mostly well-formed key traffic, plus service calls and noise
  task automatic send_random;
    int unsigned sel;
    logic [7:0]  b;
    sel = $urandom_range(99);
    if (sel < 40) begin
      // key press with occasional e0 prefix, often released after
      if ($urandom_range(3) == 0) send_beat(mk(s2k_pkg::KIND_SCAN, 8'he0, '0), 0, '0);
      b = 8'($urandom_range(1, 8'h58));
      send_beat(mk(s2k_pkg::KIND_SCAN, b, 16'($urandom)), 0, '0);
      if ($urandom_range(1)) send_beat(mk(s2k_pkg::KIND_SCAN, b | 8'h80, '0), 0, '0);
    end else if (sel < 50) begin
      // modifier toggles
      case ($urandom_range(6))
        0: b = 8'h2a; 1: b = 8'h36; 2: b = 8'h1d; 3: b = 8'h38;
        4: b = 8'h3a; 5: b = 8'h45; default: b = 8'h46;
      endcase
      if ($urandom_range(3) == 0) send_beat(mk(s2k_pkg::KIND_SCAN, 8'he0, '0), 0, '0);
      send_beat(mk(s2k_pkg::KIND_SCAN, b | ($urandom_range(1) ? 8'h80 : 8'h00), '0), 0, '0);
    end else if (sel < 55) begin
      send_beat(mk(s2k_pkg::KIND_SCAN, 8'($urandom), 16'($urandom)), 0, '0);
    end else if (sel < 62) begin
      send_beat(mk(s2k_pkg::KIND_STORE, 8'($urandom), 16'($urandom)), 0, '0);
    end else begin
      send_beat(mk(s2k_pkg::kind_e'($urandom_range(1, 7)), 8'($urandom), 16'($urandom)),
                0, '0);
    end
  endtask

  // directed table: stimulus and, where obvious, typed-in result
  typedef struct {
    s2k_pkg::in_beat_t  it;
    bit                 has_exp;
    s2k_pkg::out_beat_t exp_b;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t row_of(input s2k_pkg::kind_e k, input logic [7:0] b,
                                      input logic [15:0] w, input bit he,
                                      input logic [15:0] rw, input logic [2:0] efr);
    dir_row_t d;
    d.it = mk(k, b, w);
    d.has_exp = he;
    d.exp_b = {rw, efr};
    return d;
  endfunction

  initial begin
    s2k_pkg::out_beat_t none;
    none = '0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cyc_cnt = 0;
    err_cnt = 0;
    hold_off = 1'b0;
    src_idle_pct = 24;
    snk_idle_pct = 86;
    kbd_flags = '0;
    kbd_prefix = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue after reset, flag queries zero
    dir_rows.push_back(row_of(s2k_pkg::KIND_READ,     8'h00, 16'h0000, 1, 16'h0, 3'b100));
    dir_rows.push_back(row_of(s2k_pkg::KIND_PEEK_EXT, 8'hff, 16'hffff, 1, 16'h0, 3'b100));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SHIFT,    8'h00, 16'h0000, 1, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_EXTFLAGS, 8'h00, 16'h0000, 1, 16'h0, 3'b000));
    // plain key, store extremes, reads back
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h1e, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_STORE,    8'h00, 16'hffff, 1, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_STORE,    8'h00, 16'h0000, 1, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_READ,     8'h00, 16'h0000, 1, 16'h1e61, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_PEEK,     8'h00, 16'h0000, 1, 16'hffff, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_READ_EXT, 8'h00, 16'h0000, 1, 16'hffff, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_READ,     8'h00, 16'h0000, 1, 16'h0, 3'b000));
    // prefix byte, extended enter, fake shift, sysreq
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'he0, 16'h0000, 1, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h1c, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'he0, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h2a, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h54, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_PEEK,     8'h00, 16'h0000, 1, 16'h1c0d, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_READ_EXT, 8'h00, 16'h0000, 1, 16'he00d, 3'b000));
    // pause: e1 1d 45, then an unknown byte
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'he1, 16'h0000, 1, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h1d, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h45, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h7f, 16'h0000, 1, 16'h0, 3'b000));
    // ctrl + alt + del
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h1d, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h38, 16'h0000, 0, 16'h0, 3'b000));
    dir_rows.push_back(row_of(s2k_pkg::KIND_SCAN,     8'h53, 16'h0000, 1, 16'h0, 3'b001));

    foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp_b);
    // release the modifiers again
    send_beat(mk(s2k_pkg::KIND_SCAN, 8'h9d, '0), 0, none);
    send_beat(mk(s2k_pkg::KIND_SCAN, 8'hb8, '0), 0, none);

    // fill past the queue depth to hit the drop path, then drain
    for (int i = 0; i < Depth + 3; i++)
      send_beat(mk(s2k_pkg::KIND_STORE, '0, 16'($urandom)), 0, none);
    for (int i = 0; i < Depth + 1; i++) send_beat(mk(s2k_pkg::KIND_READ, '0, '0), 0, none);

    // three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 86 : 0;
      snk_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 24 : 0;
      for (int i = 0; i < 140; i++) send_random();
    end

    // long receiver hold-off while the sender keeps offering beats
    hold_off = 1'b1;
    fork
      repeat (60) send_random();
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    in_ch.valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/s2k_pkg.sv
hdl/s2k_if.sv
hdl/s2k_decode.sv
hdl/s2k_fifo.sv
hdl/scancode_to_keycode_with_key_fifo.sv
dv/tb_top.sv
